@@ rtl/lssf_pkg.sv @@
// Shared types, widths and constants for the least-squares segment fit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package lssf_pkg;

  localparam int MaxPoints = 1024;
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int CrdW      = 16;
  localparam int SxW       = CrdW + CntW;
  localparam int SxxW      = 2 * CrdW - 2 + CntW;
  localparam int SxyW      = 2 * CrdW - 1 + CntW;
  localparam int CfgW      = 17;
  localparam int SqW       = CrdW + 1;
  localparam int MagW      = 2 * CntW + 30;
  localparam int DvdW      = MagW + 16;
  localparam int BW        = 32;
  localparam int PW        = (BW + SxW > CntW + SxyW) ? BW + SxW : CntW + SxyW;
  localparam int IcW       = PW + 2;
  localparam int CtrW      = $clog2(DvdW);
  localparam int JqDepth   = 2;
  localparam int JqAw      = $clog2(JqDepth);

  typedef enum logic [1:0] {
    CfgCandleMin = 2'd0,
    CfgCandleMax = 2'd1,
    CfgFurnMin   = 2'd2,
    CfgFurnMax   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_NXX, S_SXX, S_NXY, S_SXY, S_DXX, S_DYY, S_SQRT,
    S_CX, S_CY, S_SLP, S_SMX, S_ICP, S_DONE
  } state_e;

  typedef struct packed {
    logic [CfgW-1:0] candle_min;
    logic [CfgW-1:0] candle_max;
    logic [CfgW-1:0] furn_min;
    logic [CfgW-1:0] furn_max;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0]        n;
    logic signed [SxW-1:0]  sx;
    logic signed [SxW-1:0]  sy;
    logic [SxxW-1:0]        sxx;
    logic signed [SxyW-1:0] sxy;
    logic [CrdW-1:0]        dxm;
    logic [CrdW-1:0]        dym;
  } job_t;

  typedef struct packed {
    logic signed [31:0]     slope;
    logic signed [31:0]     icpt;
    logic signed [CrdW-1:0] cx;
    logic signed [CrdW-1:0] cy;
    logic [SqW-1:0]         len;
    logic                   candle;
    logic                   furn;
    logic                   vert;
    logic [CntW-1:0]        count;
  } res_t;

endpackage

@@ rtl/least_squares_segment_fit.sv @@
// Least-squares segment fit top level: config registers, front end, job queue, sequencer.
// Points are taken one per cycle while the two-entry job queue has room. A fit runs seven
// shift-add multiplies, a root and four divides in turn (six multiplies, a root and two
// divides when vertical), one fit at a time; a finished fit waits until the previous result is popped.
// Reset (asynchronous, active low) clears sums, queue and the result valid flag; config returns to defaults.
// Depends on lssf_pkg, lssf_front, lssf_jobq, lssf_back.
`timescale 1ns / 1ps
module least_squares_segment_fit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic signed [15:0]         point_x_i,
  input  logic signed [15:0]         point_y_i,
  input  logic                       last_point_i,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [31:0]         fit_slope_o,
  output logic signed [31:0]         fit_intercept_o,
  output logic signed [15:0]         centroid_x_o,
  output logic signed [15:0]         centroid_y_o,
  output logic [16:0]                segment_length_o,
  output logic                       is_candle_o,
  output logic                       is_furniture_o,
  output logic                       vertical_o,
  output logic [10:0]                point_count_o,
  input  logic                       cfg_we_i,
  input  lssf_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [16:0]                cfg_data_i
);
  import lssf_pkg::*;

  cfg_t cfg_q;
  job_t job_in, job_out;
  res_t res;
  logic q_full, q_empty, job_push, job_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.candle_min <= CfgW'(256);
      cfg_q.candle_max <= CfgW'(1024);
      cfg_q.furn_min   <= CfgW'(2304);
      cfg_q.furn_max   <= CfgW'(3328);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCandleMin: cfg_q.candle_min <= cfg_data_i;
        CfgCandleMax: cfg_q.candle_max <= cfg_data_i;
        CfgFurnMin:   cfg_q.furn_min   <= cfg_data_i;
        CfgFurnMax:   cfg_q.furn_max   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lssf_front u_front (
    .clk_i, .rst_ni,
    .push_i     (push),
    .x_i        (point_x_i),
    .y_i        (point_y_i),
    .last_i     (last_point_i),
    .q_full_i   (q_full),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  lssf_jobq u_jobq (
    .clk_i, .rst_ni,
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (job_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  lssf_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (!q_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .cfg_i       (cfg_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign fit_slope_o      = res.slope;
  assign fit_intercept_o  = res.icpt;
  assign centroid_x_o     = res.cx;
  assign centroid_y_o     = res.cy;
  assign segment_length_o = res.len;
  assign is_candle_o      = res.candle;
  assign is_furniture_o   = res.furn;
  assign vertical_o       = res.vert;
  assign point_count_o    = res.count;

endmodule

@@ rtl/lssf_front.sv @@
// Front end: takes points, keeps the running sums and the first point,
// and hands a fit job to the job queue on the last point. Uses lssf_pkg.
`timescale 1ns / 1ps
module lssf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic signed [15:0]          x_i,
  input  logic signed [15:0]          y_i,
  input  logic                        last_i,
  input  logic                        q_full_i,
  output logic                        full_o,
  output logic                        job_push_o,
  output lssf_pkg::job_t              job_o
);
  import lssf_pkg::*;

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [SxW-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [SxxW-1:0]        sxx_q, sxx_d;
  logic signed [SxyW-1:0] sxy_q, sxy_d;
  logic signed [CrdW-1:0] fx_q, fy_q, fx, fy;
  logic signed [2*CrdW-1:0] xx, xy;
  logic signed [CrdW:0]   dx, dy;
  logic                   accept, room;

  assign accept     = push_i && !q_full_i;
  assign full_o     = q_full_i;
  assign job_push_o = accept && last_i;

  always_comb begin
    room  = cnt_q < CntW'(MaxPoints);
    fx    = (cnt_q == '0) ? x_i : fx_q;
    fy    = (cnt_q == '0) ? y_i : fy_q;
    xx    = x_i * x_i;
    xy    = x_i * y_i;
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sxx_d = sxx_q;
    sxy_d = sxy_q;
    if (room) begin
      cnt_d = cnt_q + 1'b1;
      sx_d  = sx_q + SxW'(x_i);
      sy_d  = sy_q + SxW'(y_i);
      sxx_d = sxx_q + SxxW'($unsigned(xx));
      sxy_d = sxy_q + SxyW'(xy);
    end
    dx = (CrdW+1)'(x_i) - (CrdW+1)'(fx);
    dy = (CrdW+1)'(y_i) - (CrdW+1)'(fy);
    job_o.n   = cnt_d;
    job_o.sx  = sx_d;
    job_o.sy  = sy_d;
    job_o.sxx = sxx_d;
    job_o.sxy = sxy_d;
    job_o.dxm = dx[CrdW] ? CrdW'(-dx) : CrdW'(dx);
    job_o.dym = dy[CrdW] ? CrdW'(-dy) : CrdW'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
    end else if (accept) begin
      if (last_i) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        sxy_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        sxx_q <= sxx_d;
        sxy_q <= sxy_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_q == '0) begin
      fx_q <= x_i;
      fy_q <= y_i;
    end
  end

endmodule

@@ rtl/lssf_jobq.sv @@
// Short queue of fit jobs between the front end and the fit sequencer.
// Uses lssf_pkg for the job type and depth.
`timescale 1ns / 1ps
module lssf_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lssf_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lssf_pkg::job_t data_o
);
  import lssf_pkg::*;

  job_t            mem_q [JqDepth];
  logic [JqAw-1:0] wr_q, rd_q;
  logic [JqAw:0]   cnt_q;

  assign full_o  = cnt_q == (JqAw+1)'(JqDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ rtl/lssf_back.sv @@
// Fit sequencer: shift-add multiplier, restoring divider and bit-pair root
// shared over the steps of one fit, plus the result register. Uses lssf_pkg.
`timescale 1ns / 1ps
module lssf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  lssf_pkg::job_t job_i,
  output logic           job_pop_o,
  input  lssf_pkg::cfg_t cfg_i,
  input  logic           pop_i,
  output logic           empty_o,
  output lssf_pkg::res_t res_o
);
  import lssf_pkg::*;

  function automatic logic [31:0] sat32(input logic neg, input logic [DvdW-1:0] mag);
    logic [31:0] r;
    if (!neg) r = (mag > DvdW'(32'h7fff_ffff)) ? 32'h7fff_ffff : mag[31:0];
    else r = (mag > DvdW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-mag[31:0]);
    return r;
  endfunction

  state_e state_q, state_d;
  logic [CtrW-1:0] cnt_q;
  job_t job_q;
  logic [PW-1:0] mul_a_q, mul_p_q, mul_p_nx;
  logic [BW-1:0] mul_b_q;
  logic [DvdW-1:0] dvd_q, quo_q, quo_nx;
  logic [MagW-1:0] dvs_q, rem_q, rem_nx;
  logic [MagW:0] remsh;
  logic ge;
  logic [2*SqW-1:0] sqv_q;
  logic [SqW-1:0] root_q, root_nx;
  logic [SqW+1:0] srem_q, srem_nx;
  logic [SqW+3:0] srsh, trial;
  logic sge;
  logic signed [PW:0] t1_q, sp_c, sprod;
  logic signed [MagW:0] den_q, num_q;
  logic signed [PW+1:0] dd;
  logic vert_q, icneg_q, last_step, adv, res_valid_q;
  logic [SqW-1:0] len_q;
  logic signed [CrdW-1:0] cx_q, cy_q;
  logic signed [31:0] slope_q, icpt_q, slope_c;
  logic [31:0] slope_m;
  logic [SxW-1:0] sx_m, sy_m;
  logic [SxyW-1:0] sxy_m;
  logic [MagW-1:0] num_m;
  logic signed [IcW-1:0] ic_c;
  logic [IcW-1:0] ic_m;
  logic candle, furn;
  res_t res_q;

  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

  always_comb begin
    sx_m  = job_q.sx[SxW-1] ? SxW'(-job_q.sx) : SxW'(job_q.sx);
    sy_m  = job_q.sy[SxW-1] ? SxW'(-job_q.sy) : SxW'(job_q.sy);
    sxy_m = job_q.sxy[SxyW-1] ? SxyW'(-job_q.sxy) : SxyW'(job_q.sxy);
    num_m = num_q[MagW] ? MagW'(-num_q) : MagW'(num_q);
    mul_p_nx = mul_p_q + (mul_b_q[0] ? mul_a_q : '0);
    remsh  = {rem_q, dvd_q[DvdW-1]};
    ge     = remsh >= {1'b0, dvs_q};
    rem_nx = ge ? MagW'(remsh - {1'b0, dvs_q}) : MagW'(remsh);
    quo_nx = {quo_q[DvdW-2:0], ge};
    srsh    = {srem_q, sqv_q[2*SqW-1 -: 2]};
    trial   = (SqW+4)'({root_q, 2'b01});
    sge     = srsh >= trial;
    srem_nx = sge ? (SqW+2)'(srsh - trial) : (SqW+2)'(srsh);
    root_nx = {root_q[SqW-2:0], sge};
    slope_c = sat32(num_q[MagW], quo_nx);
    slope_m = slope_c[31] ? 32'(-slope_c) : slope_c;
    sprod   = $signed({1'b0, mul_p_nx});
    sp_c    = (slope_q[31] ^ job_q.sx[SxW-1]) ? -sprod : sprod;
    ic_c    = (IcW'(job_q.sy) <<< 16) - IcW'(sp_c);
    ic_m    = ic_c[IcW-1] ? IcW'(-ic_c) : IcW'(ic_c);
    dd      = (PW+2)'(t1_q) - (PW+2)'(sprod);
    candle  = len_q > cfg_i.candle_min && len_q < cfg_i.candle_max;
    furn    = !candle && len_q > cfg_i.furn_min && len_q < cfg_i.furn_max;
  end

  always_comb begin
    unique case (state_q)
      S_NXX, S_SXX, S_NXY, S_SXY, S_DXX, S_DYY, S_SMX: last_step = cnt_q == CtrW'(BW - 1);
      S_CX, S_CY, S_SLP, S_ICP: last_step = cnt_q == CtrW'(DvdW - 1);
      S_SQRT: last_step = cnt_q == CtrW'(SqW - 1);
      default: last_step = 1'b1;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = S_NXX;
        end
      end
      S_NXX:  if (last_step) state_d = S_SXX;
      S_SXX:  if (last_step) state_d = S_NXY;
      S_NXY:  if (last_step) state_d = S_SXY;
      S_SXY:  if (last_step) state_d = S_DXX;
      S_DXX:  if (last_step) state_d = S_DYY;
      S_DYY:  if (last_step) state_d = S_SQRT;
      S_SQRT: if (last_step) state_d = S_CX;
      S_CX:   if (last_step) state_d = S_CY;
      S_CY:   if (last_step) state_d = vert_q ? S_DONE : S_SLP;
      S_SLP:  if (last_step) state_d = S_SMX;
      S_SMX:  if (last_step) state_d = S_ICP;
      S_ICP:  if (last_step) state_d = S_DONE;
      S_DONE: if (!res_valid_q || pop_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign adv = state_d != state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= adv ? '0 : cnt_q + 1'b1;
      if (state_q == S_DONE && adv) res_valid_q <= 1'b1;
      else if (pop_i) res_valid_q <= 1'b0;
    end
  end

  // datapath: capture on the last step of a state, load on entry to the next
  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    if (last_step) begin
      unique case (state_q)
        S_NXX: t1_q <= sprod;
        S_SXX: begin
          den_q  <= dd[MagW:0];
          vert_q <= dd <= 0;
          if (dd <= 0) begin
            slope_q <= '0;
            icpt_q  <= '0;
          end
        end
        S_NXY: t1_q <= job_q.sxy[SxyW-1] ? -sprod : sprod;
        S_SXY: num_q <= (job_q.sx[SxW-1] ^ job_q.sy[SxW-1]) ?
                        MagW'(t1_q + sprod) : MagW'(dd);
        S_DXX: t1_q <= sprod;
        S_SQRT: len_q <= root_nx;
        S_CX: cx_q <= job_q.sx[SxW-1] ? CrdW'(-quo_nx[CrdW-1:0]) : quo_nx[CrdW-1:0];
        S_CY: cy_q <= job_q.sy[SxW-1] ? CrdW'(-quo_nx[CrdW-1:0]) : quo_nx[CrdW-1:0];
        S_SLP: slope_q <= slope_c;
        S_SMX: icneg_q <= ic_c[IcW-1];
        S_ICP: icpt_q <= sat32(icneg_q, quo_nx);
        default: ;
      endcase
    end
    if (adv) begin
      case (state_d)
        S_NXX: begin
          mul_a_q <= PW'(job_i.sxx);
          mul_b_q <= BW'(job_i.n);
          mul_p_q <= '0;
        end
        S_SXX, S_SXY: begin
          mul_a_q <= PW'(sx_m);
          mul_b_q <= (state_d == S_SXX) ? BW'(sx_m) : BW'(sy_m);
          mul_p_q <= '0;
        end
        S_NXY: begin
          mul_a_q <= PW'(sxy_m);
          mul_b_q <= BW'(job_q.n);
          mul_p_q <= '0;
        end
        S_DXX, S_DYY: begin
          mul_a_q <= (state_d == S_DXX) ? PW'(job_q.dxm) : PW'(job_q.dym);
          mul_b_q <= (state_d == S_DXX) ? BW'(job_q.dxm) : BW'(job_q.dym);
          mul_p_q <= '0;
        end
        S_SQRT: begin
          sqv_q  <= (2*SqW)'(PW'(t1_q) + mul_p_nx);
          root_q <= '0;
          srem_q <= '0;
        end
        S_CX, S_CY, S_SLP, S_ICP: begin
          unique case (state_d)
            S_CX:    dvd_q <= DvdW'(sx_m);
            S_CY:    dvd_q <= DvdW'(sy_m);
            S_SLP:   dvd_q <= {num_m, 16'b0};
            default: dvd_q <= DvdW'(ic_m >> 16);
          endcase
          dvs_q <= (state_d == S_SLP) ? den_q[MagW-1:0] : MagW'(job_q.n);
          rem_q <= '0;
          quo_q <= '0;
        end
        S_SMX: begin
          mul_a_q <= PW'(sx_m);
          mul_b_q <= slope_m;
          mul_p_q <= '0;
        end
        S_IDLE: begin
          res_q.slope  <= slope_q;
          res_q.icpt   <= icpt_q;
          res_q.cx     <= cx_q;
          res_q.cy     <= cy_q;
          res_q.len    <= len_q;
          res_q.candle <= candle;
          res_q.furn   <= furn;
          res_q.vert   <= vert_q;
          res_q.count  <= job_q.n;
        end
        default: ;
      endcase
    end else begin
      mul_a_q <= mul_a_q << 1;
      mul_b_q <= mul_b_q >> 1;
      mul_p_q <= mul_p_nx;
      dvd_q   <= dvd_q << 1;
      rem_q   <= rem_nx;
      quo_q   <= quo_nx;
      sqv_q   <= sqv_q << 2;
      root_q  <= root_nx;
      srem_q  <= srem_nx;
    end
  end

  a_vert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.vert |-> res_q.slope == 0 && res_q.icpt == 0)
    else $error("vertical result with nonzero fit");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.candle && res_q.furn))
    else $error("candle and furniture both set");
  a_count_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.count != '0)
    else $error("result with zero points");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> state_q == S_NXX && cnt_q == '0)
    else $error("job taken without starting a fit");

endmodule

@@ tb/sv/tb_least_squares_segment_fit.sv @@
// Self-checking testbench for least_squares_segment_fit: directed table, then random segments.
// Expected fits: in-bench predictor of the running sums or a fixed row; depends on lssf_pkg.
`timescale 1ns / 1ps
module tb_least_squares_segment_fit;
  import lssf_pkg::*;

  localparam int CycleLimit = 10000000;
  localparam int DrainWait  = 700;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 last;
    bit                 known;
    res_t               want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] point_x_i = '0;
  logic signed [15:0] point_y_i = '0;
  logic               last_point_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] fit_slope_o;
  logic signed [31:0] fit_intercept_o;
  logic signed [15:0] centroid_x_o;
  logic signed [15:0] centroid_y_o;
  logic [16:0]        segment_length_o;
  logic               is_candle_o;
  logic               is_furniture_o;
  logic               vertical_o;
  logic [10:0]        point_count_o;
  logic               cfg_we_i = 1'b0;
  cfg_idx_e           cfg_idx_i = CfgCandleMin;
  logic [16:0]        cfg_data_i = '0;

  least_squares_segment_fit i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // fit model state
  longint unsigned candle_lo, candle_hi, furn_lo, furn_hi;
  int     pts_n;
  longint pts_sx, pts_sy, pts_sxx, pts_sxy;
  longint first_x, first_y;

  res_t       fit_q[$];
  stim_row_t  rows[$];
  int         errors = 0;
  int         cycles = 0;
  int         stall_left = 0;
  bit         quiet = 1'b0;

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  function automatic longint slope_q16(longint num, longint den);
    bit neg;
    longint unsigned mag, q, r, m;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    r = mag % den;
    if (q >= 65536) begin
      m = 64'd1 << 32;
    end else begin
      m = q;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        m = m << 1;
        if (r >= den) begin
          r -= den;
          m |= 1;
        end
      end
    end
    if (neg) begin
      if (m > 64'd2147483648) m = 64'd2147483648;
      return -longint'(m);
    end
    if (m > 64'd2147483647) m = 64'd2147483647;
    return longint'(m);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit fit_point(longint x, longint y, bit last, output res_t r);
    longint num, den, slope, icpt, dx, dy;
    longint unsigned len;
    bit candle, furn;
    r = '0;
    if (pts_n == 0) begin
      first_x = x;
      first_y = y;
    end
    if (pts_n < MaxPoints) begin
      pts_n++;
      pts_sx += x;
      pts_sy += y;
      pts_sxx += x * x;
      pts_sxy += x * y;
    end
    if (!last) return 1'b0;
    den = pts_n * pts_sxx - pts_sx * pts_sx;
    num = pts_n * pts_sxy - pts_sx * pts_sy;
    slope = 0;
    icpt = 0;
    if (den > 0) begin
      slope = slope_q16(num, den);
      icpt = (pts_sy * 65536 - slope * pts_sx) / (pts_n * 65536);
      if (icpt > 64'sd2147483647) icpt = 64'sd2147483647;
      if (icpt < -64'sd2147483648) icpt = -64'sd2147483648;
    end
    dx = x - first_x;
    dy = y - first_y;
    len = root_floor(dx * dx + dy * dy);
    candle = len > candle_lo && len < candle_hi;
    furn = !candle && len > furn_lo && len < furn_hi;
    r.slope  = slope[31:0];
    r.icpt   = icpt[31:0];
    r.cx     = 16'(pts_sx / pts_n);
    r.cy     = 16'(pts_sy / pts_n);
    r.len    = len[16:0];
    r.candle = candle;
    r.furn   = furn;
    r.vert   = den <= 0;
    r.count  = pts_n[10:0];
    pts_n = 0;
    pts_sx = 0;
    pts_sy = 0;
    pts_sxx = 0;
    pts_sxy = 0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // call right after a rising edge
  task automatic send_point(stim_row_t s);
    int gap;
    res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    point_x_i <= s.x;
    point_y_i <= s.y;
    last_point_i <= s.last;
    do @(posedge clk_i); while (full);
    if (fit_point(s.x, s.y, s.last, r)) fit_q.insert(fit_q.size(), s.known ? s.want : r);
  endtask

  task automatic add_row(int x, int y, bit last);
    stim_row_t s;
    s.x = 16'(x);
    s.y = 16'(y);
    s.last = last;
    s.known = 1'b0;
    s.want = '0;
    rows.insert(rows.size(), s);
  endtask

  task automatic add_single(int x, int y);
    stim_row_t s;
    s.x = 16'(x);
    s.y = 16'(y);
    s.last = 1'b1;
    s.known = 1'b1;
    s.want = '{slope: 0, icpt: 0, cx: 16'(x), cy: 16'(y), len: 0, candle: 0, furn: 0,
               vert: 1, count: 1};
    rows.insert(rows.size(), s);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [16:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      CfgCandleMin: candle_lo = v;
      CfgCandleMax: candle_hi = v;
      CfgFurnMin:   furn_lo = v;
      default:      furn_hi = v;
    endcase
  endtask

  task automatic set_windows(int a, int b, int c, int d);
    wait_idle();
    write_reg(CfgCandleMin, 17'(a));
    write_reg(CfgCandleMax, 17'(b));
    write_reg(CfgFurnMin, 17'(c));
    write_reg(CfgFurnMax, 17'(d));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_segments(int budget);
    stim_row_t s;
    int seg_len, mode, k, c, sent;
    sent = 0;
    s.known = 1'b0;
    s.want = '0;
    while (sent < budget) begin
      seg_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      mode = $urandom_range(0, 3);
      k = $urandom_range(0, 8) - 4;
      c = $urandom_range(0, 2000) - 1000;
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < seg_len; i++) begin
        case (mode)
          0: begin
            s.x = 16'($urandom());
            s.y = 16'($urandom());
          end
          1: begin
            s.x = 16'($urandom_range(0, 1200) - 600);
            s.y = 16'($urandom_range(0, 1200) - 600);
          end
          2: begin
            s.x = 16'($urandom_range(0, 3000) - 1500);
            s.y = 16'(k * s.x + c + $urandom_range(0, 20) - 10);
          end
          default: begin
            s.x = 16'((i % 2) ? 100 : 100 + $urandom_range(0, 1));
            s.y = 16'($urandom_range(0, 4000) - 2000);
          end
        endcase
        s.last = (i == seg_len - 1);
        send_point(s);
      end
      sent += seg_len;
    end
  endtask

  task automatic run_full_segment(int pts);
    stim_row_t s;
    s.known = 1'b0;
    s.want = '0;
    quiet = 1'b0;
    for (int i = 0; i < pts; i++) begin
      s.x = 16'($urandom_range(0, 8000) - 4000);
      s.y = 16'($urandom_range(0, 8000) - 4000);
      s.last = (i == pts - 1);
      send_point(s);
    end
  endtask

  always @(posedge clk_i) begin
    res_t w;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && pop && !empty) begin
      if (fit_q.size() == 0) begin
        report("unexpected item", 1, 0);
      end else begin
        w = fit_q.pop_front();
        if (fit_slope_o !== w.slope) report("fit_slope", fit_slope_o, w.slope);
        if (fit_intercept_o !== w.icpt) report("fit_intercept", fit_intercept_o, w.icpt);
        if (centroid_x_o !== w.cx) report("centroid_x", centroid_x_o, w.cx);
        if (centroid_y_o !== w.cy) report("centroid_y", centroid_y_o, w.cy);
        if (segment_length_o !== w.len) report("segment_length", segment_length_o, w.len);
        if (is_candle_o !== w.candle) report("is_candle", is_candle_o, w.candle);
        if (is_furniture_o !== w.furn) report("is_furniture", is_furniture_o, w.furn);
        if (vertical_o !== w.vert) report("vertical", vertical_o, w.vert);
        if (point_count_o !== w.count) report("point_count", point_count_o, w.count);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 99) < 8) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    candle_lo = 256;
    candle_hi = 1024;
    furn_lo = 2304;
    furn_hi = 3328;
    pts_n = 0;
    pts_sx = 0;
    pts_sy = 0;
    pts_sxx = 0;
    pts_sxy = 0;
    first_x = 0;
    first_y = 0;

    add_single(32767, -32768);
    add_single(-32768, 32767);
    add_single(0, 0);
    add_row(-32768, -32768, 0);
    add_row(32767, 32767, 1);
    add_row(0, -32768, 0);
    add_row(1, 32767, 1);
    add_row(0, 32767, 0);
    add_row(1, -32768, 1);
    add_row(500, 10, 0);
    add_row(500, -700, 0);
    add_row(500, 90, 1);
    add_row(0, 0, 0);
    add_row(256, 0, 1);
    add_row(0, 0, 0);
    add_row(512, 0, 1);
    add_row(0, 0, 0);
    add_row(2560, 0, 1);
    add_row(0, 0, 0);
    add_row(3328, 0, 1);
    add_row(-100, 300, 0);
    add_row(200, -50, 0);
    add_row(1000, 2000, 1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_point(rows[i]);

    run_segments(300);
    run_full_segment(1030);
    set_windows(0, 0, 0, 0);
    run_segments(80);
    set_windows(131071, 131071, 131071, 131071);
    run_segments(80);
    set_windows(0, 131071, 0, 131071);
    run_segments(80);
    set_windows(300, 2000, 2500, 60000);
    run_segments(80);
    set_windows($urandom_range(0, 131071), $urandom_range(0, 131071),
                $urandom_range(0, 131071), $urandom_range(0, 131071));
    run_segments(80);

    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
